// ===== hw/rtl/qse_pkg.sv =====
// Shared constants, types and port bundles of the quicksort engine.
`default_nettype none

package qse_pkg;

  localparam int CAPACITY    = 16;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = IDX_W + 1;
  localparam int STACK_SLOTS = 16;
  localparam int SP_W        = $clog2(STACK_SLOTS);
  localparam int DEPTH_W     = SP_W + 1;
  localparam int WORD_W      = 32;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    idx_t lo;
    idx_t hi;
  } range_t;

  typedef struct packed {
    logic   push;
    logic   pop;
    range_t rng;
  } stk_cmd_t;

  typedef struct packed {
    logic  we;
    idx_t  waddr;
    word_t wdata;
    idx_t  raddr;
  } elem_req_t;

endpackage

`default_nettype wire

// ===== hw/rtl/quicksort_engine_unit.sv =====
// Top level of the quicksort engine: load, sort and output sequencer.
//
//   Channel  | Ports                               | Transfer
//   ---------+-------------------------------------+---------------------------------
//   input    | start, busy, value, last            | start high while busy is low
//   result   | strobe, value_res, last_res,        | every cycle in which strobe
//            | overflow                            | is high (no back pressure)
//
// Loading takes one element per cycle in which start is high. After the
// element marked last, busy stays high while the buffer is sorted in place.
// Per range the pivot is read first, each other element is read and compared,
// each swap and the placing of the pivot take two writes, and the range is
// split; the element memory has one write port and one registered read port.
// The sorted set then leaves one result at a time, each read from the buffer
// before it is strobed. Reset clears the control state and the counts; the
// element and range memories are not cleared. The receiver cannot stall results.
`default_nettype none

module quicksort_engine_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] value,
  input  wire logic               last,
  output logic                    strobe,
  output logic signed [31:0]      value_res,
  output logic                    last_res,
  output logic                    overflow
);

  localparam int IW = qse_pkg::IDX_W;

  // Sequencer states.
  localparam logic [3:0] ST_LOAD  = 4'd0;
  localparam logic [3:0] ST_INIT  = 4'd1;
  localparam logic [3:0] ST_POP   = 4'd2;
  localparam logic [3:0] ST_POPW  = 4'd3;
  localparam logic [3:0] ST_RANGE = 4'd4;
  localparam logic [3:0] ST_PIV   = 4'd5;
  localparam logic [3:0] ST_SCAN  = 4'd6;
  localparam logic [3:0] ST_CMP   = 4'd7;
  localparam logic [3:0] ST_SWP1  = 4'd8;
  localparam logic [3:0] ST_SWP2  = 4'd9;
  localparam logic [3:0] ST_FIN1  = 4'd10;
  localparam logic [3:0] ST_FIN2  = 4'd11;
  localparam logic [3:0] ST_SPLIT = 4'd12;
  localparam logic [3:0] ST_OREAD = 4'd13;
  localparam logic [3:0] ST_OEMIT = 4'd14;

  logic [3:0]     state, state_next;
  qse_pkg::cnt_t  count, count_next;
  logic           ovf, ovf_next;
  qse_pkg::cnt_t  lo, lo_next;
  qse_pkg::cnt_t  hi, hi_next;
  qse_pkg::cnt_t  split, split_next;
  qse_pkg::cnt_t  j, j_next;
  qse_pkg::word_t pivot, pivot_next;
  qse_pkg::word_t tmp, tmp_next;

  qse_pkg::elem_req_t req;
  qse_pkg::word_t     rdata;
  qse_pkg::stk_cmd_t  cmd;
  qse_pkg::range_t    stk_rdata;
  logic               stk_empty;

  // Arithmetic on the range pointers, kept one bit wider than an index so
  // that one past the last entry is still representable.
  qse_pkg::cnt_t split_inc, split_dec, lo_inc, j_inc, count_dec;
  logic          is_final;

  assign split_inc = split + 1'b1;
  assign split_dec = split - 1'b1;
  assign lo_inc    = lo + 1'b1;
  assign j_inc     = j + 1'b1;
  assign count_dec = count - 1'b1;
  assign is_final  = (j == count_dec);

  qse_elem_mem u_elem_mem (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  qse_range_stack u_range_stack (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .rdata (stk_rdata),
    .empty (stk_empty)
  );

  always_comb begin
    state_next = state;
    count_next = count;
    ovf_next   = ovf;
    lo_next    = lo;
    hi_next    = hi;
    split_next = split;
    j_next     = j;
    pivot_next = pivot;
    tmp_next   = tmp;
    req        = '0;
    cmd        = '0;

    case (state)
      ST_LOAD: begin
        // Store the element while room is left; otherwise drop it and flag.
        if (start) begin
          if (count < qse_pkg::cnt_t'(qse_pkg::CAPACITY)) begin
            req.we     = 1'b1;
            req.waddr  = count[IW-1:0];
            req.wdata  = value;
            count_next = count + 1'b1;
          end else begin
            ovf_next = 1'b1;
          end
          if (last) begin
            state_next = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        if (count < qse_pkg::cnt_t'(2)) begin
          j_next     = '0;
          state_next = ST_OREAD;
        end else begin
          cmd.push   = 1'b1;
          cmd.rng.lo = '0;
          cmd.rng.hi = count_dec[IW-1:0];
          state_next = ST_POP;
        end
      end
      ST_POP: begin
        if (stk_empty) begin
          j_next     = '0;
          state_next = ST_OREAD;
        end else begin
          cmd.pop    = 1'b1;
          state_next = ST_POPW;
        end
      end
      ST_POPW: begin
        lo_next    = {1'b0, stk_rdata.lo};
        hi_next    = {1'b0, stk_rdata.hi};
        state_next = ST_RANGE;
      end
      ST_RANGE: begin
        if (lo < hi) begin
          req.raddr  = lo[IW-1:0];
          state_next = ST_PIV;
        end else begin
          state_next = ST_POP;
        end
      end
      ST_PIV: begin
        pivot_next = rdata;
        split_next = lo;
        j_next     = lo_inc;
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (j <= hi) begin
          req.raddr  = j[IW-1:0];
          state_next = ST_CMP;
        end else if (split == lo) begin
          state_next = ST_SPLIT;
        end else begin
          req.raddr  = split[IW-1:0];
          state_next = ST_FIN1;
        end
      end
      ST_CMP: begin
        // An element below the pivot grows the lower side by one; it is
        // swapped with the first element of the upper side, if there is one.
        if ($signed(rdata) < $signed(pivot)) begin
          split_next = split_inc;
          if (split_inc == j) begin
            j_next     = j_inc;
            state_next = ST_SCAN;
          end else begin
            tmp_next   = rdata;
            req.raddr  = split_inc[IW-1:0];
            state_next = ST_SWP1;
          end
        end else begin
          j_next     = j_inc;
          state_next = ST_SCAN;
        end
      end
      ST_SWP1: begin
        req.we     = 1'b1;
        req.waddr  = split[IW-1:0];
        req.wdata  = tmp;
        tmp_next   = rdata;
        state_next = ST_SWP2;
      end
      ST_SWP2: begin
        req.we     = 1'b1;
        req.waddr  = j[IW-1:0];
        req.wdata  = tmp;
        j_next     = j_inc;
        state_next = ST_SCAN;
      end
      ST_FIN1: begin
        req.we     = 1'b1;
        req.waddr  = lo[IW-1:0];
        req.wdata  = rdata;
        state_next = ST_FIN2;
      end
      ST_FIN2: begin
        req.we     = 1'b1;
        req.waddr  = split[IW-1:0];
        req.wdata  = pivot;
        state_next = ST_SPLIT;
      end
      ST_SPLIT: begin
        // Keep working on the smaller side and push the larger one, which
        // bounds the stack depth by the log of the capacity.
        if ((split - lo) < (hi - split)) begin
          if (split_inc < hi) begin
            cmd.push   = 1'b1;
            cmd.rng.lo = split_inc[IW-1:0];
            cmd.rng.hi = hi[IW-1:0];
          end
          if (split == lo) begin
            state_next = ST_POP;
          end else begin
            hi_next    = split_dec;
            state_next = ST_RANGE;
          end
        end else begin
          if (split > lo_inc) begin
            cmd.push   = 1'b1;
            cmd.rng.lo = lo[IW-1:0];
            cmd.rng.hi = split_dec[IW-1:0];
          end
          lo_next    = split_inc;
          state_next = ST_RANGE;
        end
      end
      ST_OREAD: begin
        req.raddr  = j[IW-1:0];
        state_next = ST_OEMIT;
      end
      ST_OEMIT: begin
        j_next = j_inc;
        if (is_final) begin
          count_next = '0;
          ovf_next   = 1'b0;
          state_next = ST_LOAD;
        end else begin
          state_next = ST_OREAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      count <= '0;
      ovf   <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      ovf   <= ovf_next;
    end
  end

  // Working pointers and held words need no reset.
  always_ff @(posedge clk) begin
    lo    <= lo_next;
    hi    <= hi_next;
    split <= split_next;
    j     <= j_next;
    pivot <= pivot_next;
    tmp   <= tmp_next;
  end

  // Results come straight from the registered read port of the buffer.
  assign busy      = (state != ST_LOAD);
  assign strobe    = (state == ST_OEMIT);
  assign value_res = $signed(rdata);
  assign last_res  = is_final;
  assign overflow  = ovf;

endmodule

`default_nettype wire

// ===== hw/rtl/qse_elem_mem.sv =====
// Element buffer: one write port and one registered read port.
`default_nettype none

module qse_elem_mem (
  input  wire logic              clk,
  input  wire qse_pkg::elem_req_t req,
  output qse_pkg::word_t         rdata
);

  qse_pkg::word_t mem [qse_pkg::CAPACITY];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/qse_range_stack.sv =====
// Stack of index ranges held in a small memory, with a registered pop read.
`default_nettype none

module qse_range_stack (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire qse_pkg::stk_cmd_t cmd,
  output qse_pkg::range_t        rdata,
  output logic                   empty
);

  qse_pkg::range_t mem [qse_pkg::STACK_SLOTS];

  logic [qse_pkg::DEPTH_W-1:0] depth;
  logic [qse_pkg::DEPTH_W-1:0] depth_dec;
  logic                        full;

  assign depth_dec = depth - 1'b1;
  assign full      = (depth == qse_pkg::DEPTH_W'(qse_pkg::STACK_SLOTS));
  assign empty     = (depth == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
    end else if (cmd.push && !full) begin
      depth <= depth + 1'b1;
    end else if (cmd.pop && !empty) begin
      depth <= depth_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push && !full) begin
      mem[depth[qse_pkg::SP_W-1:0]] <= cmd.rng;
    end
    if (cmd.pop) begin
      rdata <= mem[depth_dec[qse_pkg::SP_W-1:0]];
    end
  end

endmodule

`default_nettype wire
